// ===== hw/rtl/sckt_pkg.sv =====
// ----------------------------------------------------------------------------
// sckt_pkg
// Shared types and constants of the sorted counted key table: request and
// result payloads, request and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package sckt_pkg;

    localparam int KEY_PORT_W          = 16;
    localparam int COUNT_W             = 16;
    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int DEFAULT_KEY_BITS    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_ENTRY       = 2'd0,
        STAT_REMOVE_MISS = 2'd1,
        STAT_TABLE_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [KEY_PORT_W-1:0] key;
    } sckt_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [KEY_PORT_W-1:0] entry_key;
        logic [COUNT_W-1:0]    entry_count;
        logic                  last;
    } sckt_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_INSERT,
        S_REPORT,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

endpackage

// ===== hw/rtl/sorted_counted_key_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_counted_key_table_core
// Sorted table of distinct keys with counts, kept in one single-port memory.
// s_ (request) and m_ (result) channels both use valid/ready; a transfer
// happens when valid and ready are high at a clock edge. Requests: add one of
// a key, remove one of a key, dump the table. Successful add/remove give no
// result; a remove miss gives one remove-miss result, an add of a new key into
// a full table one table_full result. A dump gives one result per entry in
// ascending key order with last on the final one, and none if empty.
// One request is in work at a time; s_ready is high only while idle.
// Add/remove: each entry scanned takes a memory read, then a compare; each
// entry moved to open or close a slot takes a read, then a write; the update,
// insert or report then finishes the request. Dump: each entry is read, then
// passed to the result register once that is free. The memory port serialises
// all of this.
// A stalled receiver holds the result register; the sequencer waits until it
// frees. Reset (aresetn low, synchronous) empties the table and clears the
// result channel; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_counted_key_table_core #(
    parameter int TABLE_DEPTH = sckt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int KEY_BITS    = sckt_pkg::DEFAULT_KEY_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sckt_pkg::sckt_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output sckt_pkg::sckt_rsp_t m_rsp
);

    localparam int KEY_W = (KEY_BITS < sckt_pkg::KEY_PORT_W) ? KEY_BITS : sckt_pkg::KEY_PORT_W;
    localparam int MEM_W = KEY_W + sckt_pkg::COUNT_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

    sckt_pkg::state_t state_reg, state_next;

    logic [1:0]       req_reg, req_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] idx_reg, idx_next;
    logic [OCC_W-1:0] j_reg, j_next;
    logic             hit_reg, hit_next;

    logic             m_valid_reg, m_valid_next;
    sckt_pkg::sckt_rsp_t rsp_reg, rsp_next;

    logic [MEM_W-1:0] mem [TABLE_DEPTH];
    logic [MEM_W-1:0] rd_data_reg;
    logic             mem_re, mem_we;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [MEM_W-1:0] wr_data;

    logic [KEY_W-1:0]            rd_key;
    logic [sckt_pkg::COUNT_W-1:0] rd_cnt;
    logic             out_free;
    logic             s_take;
    logic             is_add;
    logic             key_less;
    logic             scan_end;
    logic             full;
    logic             dump_last;
    logic [OCC_W-1:0] j_adj;
    logic             move_done;

    assign rd_key    = rd_data_reg[MEM_W-1 -: KEY_W];
    assign rd_cnt    = rd_data_reg[sckt_pkg::COUNT_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == sckt_pkg::S_IDLE);
    assign s_take    = s_valid && s_ready;
    assign is_add    = (req_reg == sckt_pkg::REQ_ADD);
    assign key_less  = (rd_key < key_reg);
    assign scan_end  = ((idx_reg + OCC_W'(1)) == occ_reg);
    assign full      = (occ_reg == OCC_W'(TABLE_DEPTH));
    assign dump_last = ((idx_reg + OCC_W'(1)) == occ_reg);
    // add opens a slot moving entries up, remove closes one moving them down
    assign j_adj     = is_add ? (j_reg - OCC_W'(1)) : (j_reg + OCC_W'(1));
    assign move_done = is_add ? (j_adj == idx_reg) : ((j_adj + OCC_W'(1)) == occ_reg);

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sckt_pkg::S_IDLE: begin
                if (s_take) begin
                    case (s_req.req_type)
                        sckt_pkg::REQ_ADD, sckt_pkg::REQ_REMOVE: begin
                            state_next = (occ_reg == '0) ? sckt_pkg::S_DECIDE
                                                         : sckt_pkg::S_SCAN_RD;
                        end
                        sckt_pkg::REQ_DUMP: begin
                            state_next = (occ_reg == '0) ? sckt_pkg::S_IDLE
                                                         : sckt_pkg::S_DUMP_RD;
                        end
                        default: state_next = sckt_pkg::S_IDLE;
                    endcase
                end
            end
            sckt_pkg::S_SCAN_RD: state_next = sckt_pkg::S_SCAN_CMP;
            sckt_pkg::S_SCAN_CMP: begin
                if (key_less && !scan_end) begin
                    state_next = sckt_pkg::S_SCAN_RD;
                end else begin
                    state_next = sckt_pkg::S_DECIDE;
                end
            end
            sckt_pkg::S_DECIDE: begin
                if (is_add) begin
                    if (hit_reg) begin
                        state_next = sckt_pkg::S_IDLE;
                    end else if (full) begin
                        state_next = sckt_pkg::S_REPORT;
                    end else if (idx_reg == occ_reg) begin
                        state_next = sckt_pkg::S_INSERT;
                    end else begin
                        state_next = sckt_pkg::S_MOVE_RD;
                    end
                end else begin
                    if (!hit_reg) begin
                        state_next = sckt_pkg::S_REPORT;
                    end else if (rd_cnt > sckt_pkg::COUNT_W'(1) || scan_end) begin
                        state_next = sckt_pkg::S_IDLE;
                    end else begin
                        state_next = sckt_pkg::S_MOVE_RD;
                    end
                end
            end
            sckt_pkg::S_MOVE_RD: state_next = sckt_pkg::S_MOVE_WR;
            sckt_pkg::S_MOVE_WR: begin
                if (!move_done) begin
                    state_next = sckt_pkg::S_MOVE_RD;
                end else if (is_add) begin
                    state_next = sckt_pkg::S_INSERT;
                end else begin
                    state_next = sckt_pkg::S_IDLE;
                end
            end
            sckt_pkg::S_INSERT: state_next = sckt_pkg::S_IDLE;
            sckt_pkg::S_REPORT: begin
                if (out_free) begin
                    state_next = sckt_pkg::S_IDLE;
                end
            end
            sckt_pkg::S_DUMP_RD: state_next = sckt_pkg::S_DUMP_OUT;
            sckt_pkg::S_DUMP_OUT: begin
                if (out_free) begin
                    state_next = dump_last ? sckt_pkg::S_IDLE : sckt_pkg::S_DUMP_RD;
                end
            end
            default: state_next = sckt_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        req_next     = req_reg;
        key_next     = key_reg;
        occ_next     = occ_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        hit_next     = hit_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        rsp_next     = rsp_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        rd_addr      = idx_reg[IDX_W-1:0];
        wr_addr      = idx_reg[IDX_W-1:0];
        wr_data      = {key_reg, sckt_pkg::COUNT_W'(1)};
        case (state_reg)
            sckt_pkg::S_IDLE: begin
                if (s_take) begin
                    req_next = s_req.req_type;
                    key_next = s_req.key[KEY_W-1:0];
                    idx_next = '0;
                    hit_next = 1'b0;
                end
            end
            sckt_pkg::S_SCAN_RD: begin
                mem_re = 1'b1;
            end
            sckt_pkg::S_SCAN_CMP: begin
                if (key_less) begin
                    // advance; past the end the place is the occupancy
                    idx_next = idx_reg + OCC_W'(1);
                end else begin
                    hit_next = (rd_key == key_reg);
                end
            end
            sckt_pkg::S_DECIDE: begin
                if (is_add) begin
                    if (hit_reg) begin
                        mem_we  = 1'b1;
                        wr_data = {key_reg, (rd_cnt == sckt_pkg::COUNT_MAX) ? rd_cnt
                                            : rd_cnt + sckt_pkg::COUNT_W'(1)};
                    end else if (!full) begin
                        j_next = occ_reg;
                    end
                end else if (hit_reg) begin
                    if (rd_cnt > sckt_pkg::COUNT_W'(1)) begin
                        mem_we  = 1'b1;
                        wr_data = {key_reg, rd_cnt - sckt_pkg::COUNT_W'(1)};
                    end else begin
                        j_next = idx_reg;
                        if (scan_end) begin
                            occ_next = occ_reg - OCC_W'(1);
                        end
                    end
                end
            end
            sckt_pkg::S_MOVE_RD: begin
                mem_re  = 1'b1;
                rd_addr = j_adj[IDX_W-1:0];
            end
            sckt_pkg::S_MOVE_WR: begin
                mem_we  = 1'b1;
                wr_addr = j_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
                j_next  = j_adj;
                if (move_done && !is_add) begin
                    occ_next = occ_reg - OCC_W'(1);
                end
            end
            sckt_pkg::S_INSERT: begin
                mem_we   = 1'b1;
                occ_next = occ_reg + OCC_W'(1);
            end
            sckt_pkg::S_REPORT: begin
                // load only once the result register is free, so a waiting
                // transfer keeps its payload
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    rsp_next.status      = is_add ? sckt_pkg::STAT_TABLE_FULL
                                                  : sckt_pkg::STAT_REMOVE_MISS;
                    rsp_next.entry_key   = '0;
                    rsp_next.entry_count = '0;
                    rsp_next.last        = 1'b1;
                end
            end
            sckt_pkg::S_DUMP_RD: begin
                mem_re = 1'b1;
            end
            sckt_pkg::S_DUMP_OUT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    rsp_next.status      = sckt_pkg::STAT_ENTRY;
                    rsp_next.entry_key   = sckt_pkg::KEY_PORT_W'(rd_key);
                    rsp_next.entry_count = rd_cnt;
                    rsp_next.last        = dump_last;
                    idx_next             = idx_reg + OCC_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sckt_pkg::S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        j_reg   <= j_next;
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== dv/sorted_counted_key_table_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_counted_key_table_core_tb
// Self-checking bench for the sorted counted key table. Requests go in on
// the s_ channel and are mirrored in a local sorted table, which queues the
// results each one should give. Every result transfer on the m_ channel is
// checked field by field against the oldest queued result. Directed tests
// cover the empty table, ordering, a full table and back-pressure. Random
// traffic runs under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module sorted_counted_key_table_core_tb;

    localparam int TABLE_DEPTH      = 32;
    localparam int KEY_BITS         = 16;
    localparam logic [sckt_pkg::KEY_PORT_W-1:0] KEY_MASK =
        {sckt_pkg::KEY_PORT_W{1'b1}} >> (sckt_pkg::KEY_PORT_W - KEY_BITS);
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // settle time covers the longest add or remove
    localparam int SETTLE_CYCLES    = 4 * TABLE_DEPTH + 16;
    localparam int WATCHDOG_LIMIT   = 10000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 40;
    localparam int RANDOM_PER_PHASE = 75;
    localparam int POOL_SIZE        = 40;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    sckt_pkg::sckt_req_t s_req;
    logic                m_valid;
    logic                m_ready;
    sckt_pkg::sckt_rsp_t m_rsp;

    // local copy of the table contents
    logic [sckt_pkg::KEY_PORT_W-1:0] mirror_keys   [TABLE_DEPTH];
    logic [sckt_pkg::COUNT_W-1:0]    mirror_counts [TABLE_DEPTH];
    int                              mirror_fill = 0;
    sckt_pkg::sckt_rsp_t             awaited_rsps [$];
    sckt_pkg::sckt_rsp_t             head_rsp;

    logic [sckt_pkg::KEY_PORT_W-1:0] key_pool [POOL_SIZE];

    int error_count    = 0;
    int report_count   = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles   = 0;

    sorted_counted_key_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic sckt_pkg::sckt_rsp_t make_rsp(
        input logic [1:0] st,
        input logic [sckt_pkg::KEY_PORT_W-1:0] k,
        input logic [sckt_pkg::COUNT_W-1:0] c,
        input logic lst);
        sckt_pkg::sckt_rsp_t r;
        r.status      = st;
        r.entry_key   = k;
        r.entry_count = c;
        r.last        = lst;
        return r;
    endfunction

    task automatic report_mismatch(input sckt_pkg::sckt_rsp_t exp_rsp,
                                   input sckt_pkg::sckt_rsp_t act_rsp);
        string exp_txt;
        string act_txt;
        exp_txt = $sformatf("status=%0d key=%h count=%0d last=%0b", exp_rsp.status,
                            exp_rsp.entry_key, exp_rsp.entry_count, exp_rsp.last);
        act_txt = $sformatf("status=%0d key=%h count=%0d last=%0b", act_rsp.status,
                            act_rsp.entry_key, act_rsp.entry_count, act_rsp.last);
        $display("%0t: mismatch expected %s, actual %s", $time, exp_txt, act_txt);
    endtask

    // Apply one accepted request to the local table and queue its results.
    task automatic mirror_request(input sckt_pkg::sckt_req_t req);
        logic [sckt_pkg::KEY_PORT_W-1:0] k;
        int pos;
        int j;
        k = req.key & KEY_MASK;
        pos = 0;
        while (pos < mirror_fill && mirror_keys[pos] < k)
            pos++;
        case (req.req_type)
            sckt_pkg::REQ_ADD: begin
                if (pos < mirror_fill && mirror_keys[pos] == k) begin
                    if (mirror_counts[pos] != sckt_pkg::COUNT_MAX)
                        mirror_counts[pos] = mirror_counts[pos] + 1'b1;
                end else if (mirror_fill >= TABLE_DEPTH) begin
                    awaited_rsps.push_back(make_rsp(sckt_pkg::STAT_TABLE_FULL,
                                                    '0, '0, 1'b1));
                end else begin
                    for (j = mirror_fill; j > pos; j--) begin
                        mirror_keys[j]   = mirror_keys[j-1];
                        mirror_counts[j] = mirror_counts[j-1];
                    end
                    mirror_keys[pos]   = k;
                    mirror_counts[pos] = sckt_pkg::COUNT_W'(1);
                    mirror_fill++;
                end
            end
            sckt_pkg::REQ_REMOVE: begin
                if (!(pos < mirror_fill && mirror_keys[pos] == k)) begin
                    awaited_rsps.push_back(make_rsp(sckt_pkg::STAT_REMOVE_MISS,
                                                    '0, '0, 1'b1));
                end else if (mirror_counts[pos] > 1) begin
                    mirror_counts[pos] = mirror_counts[pos] - 1'b1;
                end else begin
                    for (j = pos; j + 1 < mirror_fill; j++) begin
                        mirror_keys[j]   = mirror_keys[j+1];
                        mirror_counts[j] = mirror_counts[j+1];
                    end
                    mirror_fill--;
                end
            end
            sckt_pkg::REQ_DUMP: begin
                for (j = 0; j < mirror_fill; j++)
                    awaited_rsps.push_back(make_rsp(sckt_pkg::STAT_ENTRY, mirror_keys[j],
                                                    mirror_counts[j],
                                                    j + 1 == mirror_fill));
            end
            default: begin
                // unused request code: no result, table unchanged
            end
        endcase
    endtask

    task automatic send_request(input logic [1:0] rtype,
                                input logic [sckt_pkg::KEY_PORT_W-1:0] req_key);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_req.req_type = rtype;
        s_req.key      = req_key;
        s_valid        = 1'b1;
        do @(posedge aclk); while (!s_ready);
        mirror_request(s_req);
    endtask

    // Drop valid, wait for every queued result, then let the block finish
    // any request that gives no result.
    task automatic wait_table_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (awaited_rsps.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic test_empty_table();
        set_idling(0, 0);
        send_request(sckt_pkg::REQ_DUMP, 16'hFFFF);
        send_request(sckt_pkg::REQ_REMOVE, 16'h1234);
        send_request(REQ_UNUSED, 16'hFFFF);
        wait_table_idle();
    endtask

    task automatic test_add_remove_order();
        send_request(sckt_pkg::REQ_ADD, 16'h0000);
        send_request(sckt_pkg::REQ_ADD, 16'hFFFF);
        send_request(sckt_pkg::REQ_ADD, 16'h8000);
        send_request(sckt_pkg::REQ_ADD, 16'h8000);
        send_request(sckt_pkg::REQ_ADD, 16'h0001);
        send_request(sckt_pkg::REQ_DUMP, 16'h5A5A);
        send_request(sckt_pkg::REQ_REMOVE, 16'h8000);
        send_request(sckt_pkg::REQ_REMOVE, 16'h8000);
        send_request(sckt_pkg::REQ_REMOVE, 16'h8000);
        send_request(sckt_pkg::REQ_DUMP, 16'h0000);
        send_request(sckt_pkg::REQ_REMOVE, 16'h0000);
        send_request(sckt_pkg::REQ_REMOVE, 16'hFFFF);
        send_request(sckt_pkg::REQ_DUMP, 16'h0000);
        send_request(sckt_pkg::REQ_REMOVE, 16'h0001);
        send_request(sckt_pkg::REQ_DUMP, 16'h0000);
        wait_table_idle();
    endtask

    task automatic test_table_full();
        int i;
        // top five bits are distinct, so the insertion order is scrambled
        for (i = 0; i < TABLE_DEPTH; i++)
            send_request(sckt_pkg::REQ_ADD,
                         16'((((i * 13) % 32) << 11) | ((i * 37) % 2048)));
        send_request(sckt_pkg::REQ_ADD, 16'hFFFF);
        send_request(sckt_pkg::REQ_ADD, 16'h0000);
        send_request(sckt_pkg::REQ_REMOVE, 16'hFFFF);
        send_request(sckt_pkg::REQ_DUMP, 16'h0000);
        wait_table_idle();
    endtask

    // Hold the receiver off while requests keep coming, so the result
    // register fills and the block stops taking requests.
    task automatic test_backpressure();
        rx_hold_cycles = LONG_HOLD_CYCLES;
        send_request(sckt_pkg::REQ_DUMP, 16'h0000);
        send_request(sckt_pkg::REQ_REMOVE, 16'hFFFF);
        send_request(sckt_pkg::REQ_DUMP, 16'h0000);
        send_request(sckt_pkg::REQ_ADD, 16'h1357);
        wait_table_idle();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int i;
        int sent;
        int roll;
        set_idling(tx_pct, rx_pct);
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = 16'($urandom_range(0, 65535));
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        sent = 0;
        while (sent < RANDOM_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                send_request(sckt_pkg::REQ_ADD,
                             key_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end else if (roll < 75 && mirror_fill > 0) begin
                send_request(sckt_pkg::REQ_REMOVE,
                             mirror_keys[$urandom_range(0, mirror_fill - 1)]);
            end else if (roll < 85) begin
                send_request(sckt_pkg::REQ_REMOVE,
                             key_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end else if (roll < 96) begin
                send_request(sckt_pkg::REQ_DUMP, 16'($urandom));
            end else begin
                // ignored by the block, so not counted
                send_request(REQ_UNUSED, 16'($urandom));
                sent--;
            end
            sent++;
        end
        wait_table_idle();
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_rsps.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d key=%h count=%0d last=%0b",
                             $time, m_rsp.status, m_rsp.entry_key, m_rsp.entry_count,
                             m_rsp.last);
                report_count++;
            end else begin
                head_rsp = awaited_rsps.pop_front();
                if (m_rsp.status !== head_rsp.status ||
                    m_rsp.entry_key !== head_rsp.entry_key ||
                    m_rsp.entry_count !== head_rsp.entry_count ||
                    m_rsp.last !== head_rsp.last) begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                        report_mismatch(head_rsp, m_rsp);
                    report_count++;
                end
            end
        end
    end

    // watchdog: consecutive cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        s_valid = 1'b0;
        s_req   = '0;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_add_remove_order();
        test_table_full();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(53, 0);
        test_random_traffic(0, 53);
        test_random_traffic(24, 24);

        if (error_count == 0 && awaited_rsps.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sorted_counted_key_table_core.f =====
hw/rtl/sckt_pkg.sv
hw/rtl/sorted_counted_key_table_core.sv
dv/sorted_counted_key_table_core_tb.sv
